// File: design/gbn_pkg.sv
`default_nettype none
package gbn_pkg;
  localparam int MAX_BOXES = 64;
  localparam int COORD_BITS = 12;
  localparam int IDX_BITS = $clog2(MAX_BOXES);
  localparam int CNT_BITS = $clog2(MAX_BOXES + 1);
  localparam int SCORE_BITS = 16;
  localparam int BOX_BITS = 4 * COORD_BITS + SCORE_BITS;
  localparam int AREA_BITS = 2 * COORD_BITS;
  localparam int UNI_BITS = AREA_BITS + 1;
  localparam int PROD_BITS = UNI_BITS + 16;

  localparam logic [0:0] REG_SCORE_THR = 1'b0;
  localparam logic [0:0] REG_IOU_THR = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] left;
    logic [COORD_BITS-1:0] top;
    logic [COORD_BITS-1:0] width;
    logic [COORD_BITS-1:0] height;
    logic [SCORE_BITS-1:0] score;
  } box_t;
endpackage
`default_nettype wire

// File: design/gbn_ram.sv
`default_nettype none
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/gbn_iou.sv
`default_nettype none
// overlap test: geometry registered, then threshold multiply and compare
module gbn_iou import gbn_pkg::*; (
  input  wire logic        clk,
  input  wire box_t        a,
  input  wire box_t        b,
  input  wire logic [15:0] iou_thr,
  output logic             suppress
);
  logic [COORD_BITS:0] x1, y1, x2, y2, ra, rb, ba, bb;
  logic [COORD_BITS-1:0] iw, ih;
  logic [AREA_BITS-1:0] area_a, area_b, inter;
  logic [AREA_BITS-1:0] area_a_q, area_b_q, inter_q;
  logic zero_q;
  logic [UNI_BITS-1:0] uni;
  logic [PROD_BITS-1:0] lhs, rhs;

  always_comb begin
    x1 = (a.left > b.left) ? {1'b0, a.left} : {1'b0, b.left};
    y1 = (a.top > b.top) ? {1'b0, a.top} : {1'b0, b.top};
    ra = {1'b0, a.left} + {1'b0, a.width};
    rb = {1'b0, b.left} + {1'b0, b.width};
    ba = {1'b0, a.top} + {1'b0, a.height};
    bb = {1'b0, b.top} + {1'b0, b.height};
    x2 = (ra < rb) ? ra : rb;
    y2 = (ba < bb) ? ba : bb;
    iw = (x2 > x1) ? COORD_BITS'(x2 - x1) : '0;
    ih = (y2 > y1) ? COORD_BITS'(y2 - y1) : '0;
    area_a = a.width * a.height;
    area_b = b.width * b.height;
    inter = iw * ih;
  end

  always_ff @(posedge clk) begin
    area_a_q <= area_a;
    area_b_q <= area_b;
    inter_q <= inter;
    zero_q <= (a.width == '0) || (a.height == '0) || (b.width == '0) || (b.height == '0);
  end

  always_comb begin
    uni = {1'b0, area_a_q} + {1'b0, area_b_q} - {1'b0, inter_q};
    lhs = {{(PROD_BITS - AREA_BITS - 16){1'b0}}, inter_q, 16'd0};
    rhs = PROD_BITS'(uni) * PROD_BITS'(iou_thr);
    suppress = !zero_q && (lhs > rhs);
  end
endmodule
`default_nettype wire

// File: design/greedy_box_nms.sv
// sequence: the last box loaded starts ranking, in which each stored box is scanned
// against every stored box; then each ranked box is fetched, tested against every
// kept box in turn and kept when none suppresses it; the final result strobes
// after the last ranked box is done, all through one store read port and one overlap unit.
// throughput: one box per cycle while loading, busy during the run; results come
// one per strobe, cannot be stalled. rst is synchronous, clears control state
// and resets thresholds to defaults; box store contents are undefined until written.
`default_nettype none
module greedy_box_nms import gbn_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_BITS-1:0] box_left,
  input  wire logic [COORD_BITS-1:0] box_top,
  input  wire logic [COORD_BITS-1:0] box_width,
  input  wire logic [COORD_BITS-1:0] box_height,
  input  wire logic [15:0]           box_score,
  input  wire logic                  last_box,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [15:0]           cfg_data,
  output logic                       strobe,
  output logic                       found,
  output logic [5:0]                 kept_index,
  output logic [COORD_BITS-1:0]      kept_left,
  output logic [COORD_BITS-1:0]      kept_top,
  output logic [COORD_BITS-1:0]      kept_width,
  output logic [COORD_BITS-1:0]      kept_height,
  output logic [15:0]                kept_score,
  output logic                       overflow,
  output logic                       last_result
);
  localparam logic [3:0] S_IDLE = 4'd0, S_RK_RD = 4'd1, S_RK_WT = 4'd2,
    S_RK_CMP = 4'd3, S_SP_RD = 4'd4, S_SP_WT = 4'd5, S_SP_CAND = 4'd6,
    S_KP_RD = 4'd7, S_KP_WT = 4'd8, S_KP_LD = 4'd9, S_KP_CHK = 4'd10,
    S_KP_CHK2 = 4'd11, S_EMIT = 4'd12;

  logic [3:0] state;
  logic [15:0] score_thr, iou_thr;
  logic [CNT_BITS-1:0] box_count, n_ranked, n_kept, i, j, jd;
  logic ovf;
  logic scan_v;
  logic [IDX_BITS-1:0] rank_pos;   // rank count for box i
  logic [15:0] cur_score;
  box_t cand, other, rdata, pend_box;
  logic [IDX_BITS-1:0] cand_idx, pend_idx;
  logic pend_v;
  logic emit_mid, emit_end;

  // rank memory: slot written once per qualifying box
  logic rk_we;
  logic [IDX_BITS-1:0] rk_waddr, rk_raddr, rk_rdata;
  logic bs_we;
  logic [IDX_BITS-1:0] bs_waddr, bs_raddr;
  logic kl_we;
  logic [IDX_BITS-1:0] kl_waddr, kl_raddr, kl_rdata;
  logic suppress;
  logic ahead;

  gbn_ram #(.WIDTH(BOX_BITS), .DEPTH(MAX_BOXES)) u_store (
    .clk, .we(bs_we), .waddr(bs_waddr),
    .wdata({box_left, box_top, box_width, box_height, box_score}),
    .raddr(bs_raddr), .rdata(rdata));

  gbn_ram #(.WIDTH(IDX_BITS), .DEPTH(MAX_BOXES)) u_rank (
    .clk, .we(rk_we), .waddr(rk_waddr), .wdata(i[IDX_BITS-1:0]),
    .raddr(rk_raddr), .rdata(rk_rdata));

  // indexes of kept boxes in the order they were kept
  gbn_ram #(.WIDTH(IDX_BITS), .DEPTH(MAX_BOXES)) u_kept (
    .clk, .we(kl_we), .waddr(kl_waddr), .wdata(cand_idx),
    .raddr(kl_raddr), .rdata(kl_rdata));

  gbn_iou u_iou (.clk, .a(cand), .b(other), .iou_thr, .suppress);

  wire accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign bs_we = accept && (box_count < CNT_BITS'(MAX_BOXES));
  assign bs_waddr = box_count[IDX_BITS-1:0];
  assign rk_we = (state == S_RK_CMP) && (j == box_count) && !scan_v &&
                 (cur_score >= score_thr);
  assign rk_waddr = rank_pos;
  assign kl_we = (state == S_EMIT);
  assign kl_waddr = n_kept[IDX_BITS-1:0];
  assign kl_raddr = j[IDX_BITS-1:0];
  assign emit_mid = (state == S_EMIT) && pend_v;
  assign emit_end = (state == S_SP_RD) && (i == n_ranked);

  // box jd ranks ahead of box i: higher score, or equal score and earlier arrival
  assign ahead = (jd < i) ? (rdata.score >= cur_score) : (rdata.score > cur_score);

  always_comb begin
    rk_raddr = i[IDX_BITS-1:0];
    case (state)
      S_RK_RD: bs_raddr = i[IDX_BITS-1:0];
      S_RK_CMP: bs_raddr = j[IDX_BITS-1:0];
      S_SP_WT, S_SP_CAND: bs_raddr = rk_rdata;
      S_KP_WT: bs_raddr = kl_rdata;
      default: bs_raddr = j[IDX_BITS-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      score_thr <= 16'd26214;
      iou_thr <= 16'd29491;
      box_count <= '0;
      ovf <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCORE_THR: score_thr <= cfg_data;
          REG_IOU_THR: iou_thr <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (box_count < CNT_BITS'(MAX_BOXES)) begin
              box_count <= box_count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (last_box) begin
              state <= S_RK_RD;
              i <= '0;
              j <= '0;
              n_ranked <= '0;
              n_kept <= '0;
              pend_v <= 1'b0;
            end
          end
        end
        // outer pass over i: first read box i, then scan j over all boxes
        S_RK_RD: begin
          if (i == box_count) begin
            state <= S_SP_RD;
            i <= '0;
          end else begin
            state <= S_RK_WT;
          end
        end
        S_RK_WT: begin
          state <= S_RK_CMP;
          j <= '0;
          rank_pos <= '0;
          cur_score <= rdata.score;
        end
        // store read data for box j arrives in the next cycle, so the scan ends in the cycle after j does
        S_RK_CMP: begin
          if (j != box_count) begin
            j <= j + 1'b1;
          end
          if (scan_v && rdata.score >= score_thr && ahead) begin
            rank_pos <= rank_pos + 1'b1;
          end
          if (j == box_count && !scan_v) begin
            if (cur_score >= score_thr) begin
              n_ranked <= n_ranked + 1'b1;
            end
            i <= i + 1'b1;
            state <= S_RK_RD;
          end
        end
        S_SP_RD: begin
          if (i == n_ranked) begin
            state <= S_IDLE;
            box_count <= '0;
            ovf <= 1'b0;
            pend_v <= 1'b0;
          end else begin
            state <= S_SP_WT;
          end
        end
        S_SP_WT: state <= S_SP_CAND;
        S_SP_CAND: begin
          cand <= rdata;
          cand_idx <= rk_rdata;
          j <= '0;
          state <= S_KP_RD;
        end
        S_KP_RD: begin
          if (j == n_kept) begin
            state <= S_EMIT;
          end else begin
            state <= S_KP_WT;
          end
        end
        S_KP_WT: state <= S_KP_LD;
        S_KP_LD: begin
          other <= rdata;
          state <= S_KP_CHK;
        end
        S_KP_CHK: state <= S_KP_CHK2;
        S_KP_CHK2: begin
          if (suppress) begin
            i <= i + 1'b1;
            state <= S_SP_RD;
          end else begin
            j <= j + 1'b1;
            state <= S_KP_RD;
          end
        end
        S_EMIT: begin
          n_kept <= n_kept + 1'b1;
          pend_v <= 1'b1;
          pend_box <= cand;
          pend_idx <= cand_idx;
          i <= i + 1'b1;
          state <= S_SP_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || state != S_RK_CMP) begin
      scan_v <= 1'b0;
      jd <= '0;
    end else begin
      scan_v <= (j != box_count);
      jd <= j;
    end
  end

  // whether a kept box is the last is unknown until the run ends, so one kept
  // box is held back and sent when the next is kept or the run finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit_mid || emit_end;
    end
    if (emit_mid || (emit_end && pend_v)) begin
      found <= 1'b1;
      kept_index <= pend_idx;
      kept_left <= pend_box.left;
      kept_top <= pend_box.top;
      kept_width <= pend_box.width;
      kept_height <= pend_box.height;
      kept_score <= pend_box.score;
      overflow <= ovf;
      last_result <= emit_end;
    end else if (emit_end) begin
      found <= 1'b0;
      kept_index <= '0;
      kept_left <= '0;
      kept_top <= '0;
      kept_width <= '0;
      kept_height <= '0;
      kept_score <= '0;
      overflow <= ovf;
      last_result <= 1'b1;
    end
  end

  property p_busy_no_accept;
    @(posedge clk) disable iff (rst) strobe |-> $past(busy);
  endproperty
  a_busy: assert property (p_busy_no_accept) else $error("strobe without run");

  a_count: assert property (@(posedge clk) disable iff (rst)
    box_count <= CNT_BITS'(MAX_BOXES)) else $error("box count over capacity");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    (strobe && !found) |-> last_result) else $error("empty result not last");
endmodule
`default_nettype wire
